FILE: hw/rtl/bbcm_pkg.sv
// Package of the box-corner and motion block: field widths, motion codes,
// pipeline payload types and the divider step. Depends on nothing.
`default_nettype none

package bbcm_pkg;

  localparam int POS_W  = 32;
  localparam int DIM_W  = 24;
  localparam int QUAT_W = 16;
  localparam int VEL_W  = 24;
  localparam int LIM_W  = 24;
  localparam int MOT_W  = 2;

  localparam logic [MOT_W-1:0] MOTION_UNKNOWN = 2'd0;
  localparam logic [MOT_W-1:0] MOTION_STATIC  = 2'd1;
  localparam logic [MOT_W-1:0] MOTION_MOVING  = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 24'd32768;

  // Yaw vector before and after normalisation.
  localparam int CS_W   = 34;
  localparam int MAG_W  = 33;
  localparam int NRM_W  = 30;
  localparam int SQR_W  = 60;
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;
  localparam int SQRT_STEPS = 31;
  localparam int QUO_W  = 17;
  localparam int NUM_W  = 47;
  localparam int TRIG_W = 18;
  localparam int PROD_W = 43;
  localparam int OFS_W  = 26;

  localparam logic signed [CS_W-1:0]   ONE_Q28 = 34'sd268435456;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;
  localparam logic signed [PROD_W-1:0] HALF_Q17 = 43'sd65536;

  // Fields that ride alongside the arithmetic from entry to exit.
  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic [DIM_W-1:0]        len;
    logic [DIM_W-1:0]        wid;
    logic [MOT_W-1:0]        motion;
    logic                    c_neg;
    logic                    s_neg;
  } carry_t;

  // One restoring-division lane.
  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [QUO_W-1:0]  num;
    logic [QUO_W-1:0]  quo;
  } div_t;

  function automatic div_t div_step(div_t d, logic [ROOT_W-1:0] root);
    logic [ROOT_W:0] t;
    logic            ge;
    div_t            n;
    t  = {d.rem, d.num[QUO_W-1]};
    ge = (t >= {1'b0, root});
    n.rem = ge ? ROOT_W'(t - {1'b0, root}) : t[ROOT_W-1:0];
    n.num = {d.num[QUO_W-2:0], 1'b0};
    n.quo = {d.quo[QUO_W-2:0], ge};
    return n;
  endfunction

  function automatic div_t div_init(logic [NRM_W-1:0] m, logic [ROOT_W-1:0] root);
    logic [NUM_W-1:0] n;
    div_t             d;
    n = NUM_W'({m, 16'b0}) + NUM_W'(root >> 1);
    d.rem = ROOT_W'(n[NUM_W-1:QUO_W]);
    d.num = n[QUO_W-1:0];
    d.quo = '0;
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bbcm_if.sv
// Valid/ready channel interfaces of the box-corner and motion block.
// Depends on bbcm_pkg for the field widths.
`default_nettype none

interface bbcm_obj_if;
  import bbcm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  center_x;
  logic signed [POS_W-1:0]  center_y;
  logic [DIM_W-1:0]         box_length;
  logic [DIM_W-1:0]         box_width;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  logic signed [VEL_W-1:0]  speed_x;
  logic signed [VEL_W-1:0]  speed_y;
  logic                     speed_valid;
  modport source (output valid, center_x, center_y, box_length, box_width, quat_w,
                  quat_x, quat_y, quat_z, speed_x, speed_y, speed_valid, input ready);
  modport sink (input valid, center_x, center_y, box_length, box_width, quat_w,
                quat_x, quat_y, quat_z, speed_x, speed_y, speed_valid, output ready);
endinterface

interface bbcm_res_if;
  import bbcm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] corner0_x;
  logic signed [POS_W-1:0] corner0_y;
  logic signed [POS_W-1:0] corner1_x;
  logic signed [POS_W-1:0] corner1_y;
  logic signed [POS_W-1:0] corner2_x;
  logic signed [POS_W-1:0] corner2_y;
  logic signed [POS_W-1:0] corner3_x;
  logic signed [POS_W-1:0] corner3_y;
  logic [MOT_W-1:0]        motion_class;
  modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
                  corner2_y, corner3_x, corner3_y, motion_class, input ready);
  modport sink (input valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
                corner2_y, corner3_x, corner3_y, motion_class, output ready);
endinterface

interface bbcm_cfg_if;
  import bbcm_pkg::*;
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bev_box_corners_and_motion.sv
// Top level of the bird's-eye-view box-corner and motion block.
// Depends on bbcm_pkg and the channel interfaces in bbcm_if.sv.
`default_nettype none

// One object beat in, one result beat out, one beat per cycle sustained while
// the output is not stalled. The depth is set by the 31-step square-root
// pipeline that normalises the yaw vector and the 17-step restoring dividers
// that follow it. The whole pipeline advances together: it moves whenever the
// output register is empty or its beat is being taken, so a stall at the output
// holds every stage and obj.ready falls for that cycle.
// The static speed limit register (reset 0.5 m/s) is written through cfg,
// which is always ready; write it only while no object is in flight.
module bev_box_corners_and_motion (
  input wire logic   clk,
  input wire logic   rst,
  bbcm_obj_if.sink   obj,
  bbcm_res_if.source res,
  bbcm_cfg_if.sink   cfg
);
  import bbcm_pkg::*;

  logic adv;
  logic [LIM_W-1:0] limit;

  assign adv       = !res.valid || res.ready;
  assign obj.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      limit <= cfg.data;
    end
  end

  // Stage 1: all the small products.
  logic                   p1_valid;
  carry_t                 p1_carry;
  logic signed [31:0]     p1_qyy, p1_qzz, p1_qwz, p1_qxy;
  logic [46:0]            p1_vxx, p1_vyy;
  logic [2*LIM_W-1:0]     p1_lim2;
  logic                   p1_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= obj.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_carry <= '{cx: obj.center_x, cy: obj.center_y, len: obj.box_length,
                    wid: obj.box_width, motion: MOTION_UNKNOWN, c_neg: 1'b0,
                    s_neg: 1'b0};
      p1_qyy  <= obj.quat_y * obj.quat_y;
      p1_qzz  <= obj.quat_z * obj.quat_z;
      p1_qwz  <= obj.quat_w * obj.quat_z;
      p1_qxy  <= obj.quat_x * obj.quat_y;
      p1_vxx  <= 47'(48'(obj.speed_x) * 48'(obj.speed_x));
      p1_vyy  <= 47'(48'(obj.speed_y) * 48'(obj.speed_y));
      p1_lim2 <= limit * limit;
      p1_spd  <= obj.speed_valid;
    end
  end

  // Stage 2: yaw vector c, s in Q28 and the motion class.
  logic                   p2_valid;
  carry_t                 p2_carry;
  logic signed [CS_W-1:0] p2_c, p2_s;
  logic signed [CS_W-1:0] c_calc, s_calc;
  logic [2*LIM_W-1:0]     speed2;
  carry_t                 p2_carry_next;

  always_comb begin
    c_calc = ONE_Q28 - ((CS_W'(p1_qyy) + CS_W'(p1_qzz)) <<< 1);
    s_calc = (CS_W'(p1_qwz) + CS_W'(p1_qxy)) <<< 1;
    speed2 = 48'(p1_vxx) + 48'(p1_vyy);
    p2_carry_next = p1_carry;
    if (!p1_spd) begin
      p2_carry_next.motion = MOTION_UNKNOWN;
    end else if (speed2 < p1_lim2) begin
      p2_carry_next.motion = MOTION_STATIC;
    end else begin
      p2_carry_next.motion = MOTION_MOVING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_carry <= p2_carry_next;
      p2_c     <= c_calc;
      p2_s     <= s_calc;
    end
  end

  // Stage 3: magnitudes, scaled so that the larger one fits in 30 bits.
  logic             p3_valid;
  carry_t           p3_carry;
  logic [NRM_W-1:0] p3_mc, p3_ms;
  logic [MAG_W-1:0] mc_raw, ms_raw, mx_raw;
  logic [1:0]       shift;
  carry_t           p3_carry_next;

  always_comb begin
    mc_raw = p2_c[CS_W-1] ? MAG_W'(-p2_c) : MAG_W'(p2_c);
    ms_raw = p2_s[CS_W-1] ? MAG_W'(-p2_s) : MAG_W'(p2_s);
    mx_raw = (mc_raw > ms_raw) ? mc_raw : ms_raw;
    if (mx_raw[MAG_W-1:NRM_W] == 3'b000) begin
      shift = 2'd0;
    end else if (mx_raw[MAG_W-1:NRM_W+1] == 2'b00) begin
      shift = 2'd1;
    end else if (!mx_raw[MAG_W-1]) begin
      shift = 2'd2;
    end else begin
      shift = 2'd3;
    end
    p3_carry_next       = p2_carry;
    p3_carry_next.c_neg = p2_c[CS_W-1];
    p3_carry_next.s_neg = p2_s[CS_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_carry <= p3_carry_next;
      p3_mc    <= NRM_W'(mc_raw >> shift);
      p3_ms    <= NRM_W'(ms_raw >> shift);
    end
  end

  // Stage 4: squares of the scaled magnitudes.
  logic             p4_valid;
  carry_t           p4_carry;
  logic [NRM_W-1:0] p4_mc, p4_ms;
  logic [SQR_W-1:0] p4_mc2, p4_ms2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (adv) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_carry <= p3_carry;
      p4_mc    <= p3_mc;
      p4_ms    <= p3_ms;
      p4_mc2   <= p3_mc * p3_mc;
      p4_ms2   <= p3_ms * p3_ms;
    end
  end

  // Square root, one result bit per stage. Entry 0 holds the radicand.
  logic             sq_valid [0:SQRT_STEPS];
  carry_t           sq_carry [0:SQRT_STEPS];
  logic [NRM_W-1:0] sq_mc    [0:SQRT_STEPS];
  logic [NRM_W-1:0] sq_ms    [0:SQRT_STEPS];
  logic [SQ_W-1:0]  sq_v     [0:SQRT_STEPS];
  logic [SQ_W-1:0]  sq_r     [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_carry[0] <= p4_carry;
      sq_mc[0]    <= p4_mc;
      sq_ms[0]    <= p4_ms;
      sq_v[0]     <= SQ_W'(p4_mc2) + SQ_W'(p4_ms2);
      sq_r[0]     <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = sq_r[j] + BIT;
    assign take  = (sq_v[j] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[j+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[j+1] <= sq_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_carry[j+1] <= sq_carry[j];
        sq_mc[j+1]    <= sq_mc[j];
        sq_ms[j+1]    <= sq_ms[j];
        sq_v[j+1]     <= take ? sq_v[j] - trial : sq_v[j];
        sq_r[j+1]     <= take ? (sq_r[j] >> 1) + BIT : sq_r[j] >> 1;
      end
    end
  end

  // Dividers: cos = (|c| * 2^16 + r/2) / r, sin likewise, one quotient bit a
  // stage. Entry 0 holds the rounded numerator split into remainder and bits.
  logic              dv_valid [0:QUO_W];
  carry_t            dv_carry [0:QUO_W];
  logic [ROOT_W-1:0] dv_root  [0:QUO_W];
  div_t              dv_c     [0:QUO_W];
  div_t              dv_s     [0:QUO_W];
  logic [ROOT_W-1:0] root_fin;

  assign root_fin = sq_r[SQRT_STEPS][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= sq_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_carry[0] <= sq_carry[SQRT_STEPS];
      dv_root[0]  <= root_fin;
      dv_c[0]     <= div_init(sq_mc[SQRT_STEPS], root_fin);
      dv_s[0]     <= div_init(sq_ms[SQRT_STEPS], root_fin);
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_carry[j+1] <= dv_carry[j];
        dv_root[j+1]  <= dv_root[j];
        dv_c[j+1]     <= div_step(dv_c[j], dv_root[j]);
        dv_s[j+1]     <= div_step(dv_s[j], dv_root[j]);
      end
    end
  end

  // Signed unit vector; a zero radius means a degenerate quaternion, yaw 0.
  logic                     tg_valid;
  carry_t                   tg_carry;
  logic signed [TRIG_W-1:0] tg_cos, tg_sin;
  logic signed [TRIG_W-1:0] qc, qs;
  logic                     degen;

  always_comb begin
    qc    = TRIG_W'(dv_c[QUO_W].quo);
    qs    = TRIG_W'(dv_s[QUO_W].quo);
    degen = (dv_root[QUO_W] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tg_valid <= 1'b0;
    end else if (adv) begin
      tg_valid <= dv_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tg_carry <= dv_carry[QUO_W];
      if (degen) begin
        tg_cos <= TRIG_ONE;
        tg_sin <= '0;
      end else begin
        tg_cos <= dv_carry[QUO_W].c_neg ? -qc : qc;
        tg_sin <= dv_carry[QUO_W].s_neg ? -qs : qs;
      end
    end
  end

  // Rotation products of the full length and width.
  logic                     pr_valid;
  carry_t                   pr_carry;
  logic signed [PROD_W-1:0] pr_lc, pr_ls, pr_wc, pr_ws;
  logic signed [DIM_W:0]    len_s, wid_s;

  assign len_s = {1'b0, tg_carry.len};
  assign wid_s = {1'b0, tg_carry.wid};

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (adv) begin
      pr_valid <= tg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_carry <= tg_carry;
      pr_lc    <= PROD_W'(len_s) * PROD_W'(tg_cos);
      pr_ls    <= PROD_W'(len_s) * PROD_W'(tg_sin);
      pr_wc    <= PROD_W'(wid_s) * PROD_W'(tg_cos);
      pr_ws    <= PROD_W'(wid_s) * PROD_W'(tg_sin);
    end
  end

  // Corner offsets: halve and round half up to Q16 in one shift by 17.
  // Corners run front-left, rear-left, rear-right, front-right.
  logic                     of_valid;
  carry_t                   of_carry;
  logic signed [OFS_W-1:0]  of_x [0:3];
  logic signed [OFS_W-1:0]  of_y [0:3];
  logic signed [PROD_W-1:0] raw_x [0:3];
  logic signed [PROD_W-1:0] raw_y [0:3];
  logic signed [PROD_W-1:0] rnd_x [0:3];
  logic signed [PROD_W-1:0] rnd_y [0:3];

  always_comb begin
    raw_x[0] =  pr_lc - pr_ws;
    raw_y[0] =  pr_ls + pr_wc;
    raw_x[1] = -pr_lc - pr_ws;
    raw_y[1] = -pr_ls + pr_wc;
    raw_x[2] = -pr_lc + pr_ws;
    raw_y[2] = -pr_ls - pr_wc;
    raw_x[3] =  pr_lc + pr_ws;
    raw_y[3] =  pr_ls - pr_wc;
    for (int k = 0; k < 4; k++) begin
      rnd_x[k] = raw_x[k] + HALF_Q17;
      rnd_y[k] = raw_y[k] + HALF_Q17;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      of_valid <= 1'b0;
    end else if (adv) begin
      of_valid <= pr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      of_carry <= pr_carry;
      for (int k = 0; k < 4; k++) begin
        of_x[k] <= rnd_x[k][PROD_W-1:17];
        of_y[k] <= rnd_y[k][PROD_W-1:17];
      end
    end
  end

  // Output register: translate to the centre and saturate.
  function automatic logic signed [POS_W-1:0] sat32(logic signed [POS_W-1:0] base,
                                                    logic signed [OFS_W-1:0] ofs);
    logic signed [POS_W+1:0] sum;
    sum = (POS_W+2)'(base) + (POS_W+2)'(ofs);
    if (sum > (POS_W+2)'(34'sh0_7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (sum < -(POS_W+2)'(34'sh0_8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return sum[POS_W-1:0];
    end
  endfunction

  logic signed [POS_W-1:0] cor_x [0:3];
  logic signed [POS_W-1:0] cor_y [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cor_x[k] = sat32(of_carry.cx, of_x[k]);
      cor_y[k] = sat32(of_carry.cy, of_y[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= of_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.corner0_x    <= cor_x[0];
      res.corner0_y    <= cor_y[0];
      res.corner1_x    <= cor_x[1];
      res.corner1_y    <= cor_y[1];
      res.corner2_x    <= cor_x[2];
      res.corner2_y    <= cor_y[2];
      res.corner3_x    <= cor_x[3];
      res.corner3_y    <= cor_y[3];
      res.motion_class <= of_carry.motion;
    end
  end

`ifndef SYNTH
  // The normalised yaw vector is a unit vector, so it can never vanish.
  a_trig_nonzero: assert property (@(posedge clk) disable iff (rst)
    tg_valid |-> (tg_cos != '0 || tg_sin != '0))
    else $error("yaw vector is zero");

  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    tg_valid |-> (tg_cos <= TRIG_ONE && tg_cos >= -TRIG_ONE &&
                  tg_sin <= TRIG_ONE && tg_sin >= -TRIG_ONE))
    else $error("yaw component beyond one");

  // A divider remainder always stays below the root it divides by.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_valid[QUO_W] && dv_root[QUO_W] != '0) |->
      (dv_c[QUO_W].rem < dv_root[QUO_W] && dv_s[QUO_W].rem < dv_root[QUO_W]))
    else $error("divider remainder out of range");

  // A stall freezes the pipeline: nothing may move inside it.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(of_valid) && $stable(sq_valid[SQRT_STEPS]) && $stable(tg_valid)))
    else $error("pipeline moved during a stall");

  a_motion_code: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.motion_class == MOTION_UNKNOWN ||
                   res.motion_class == MOTION_STATIC ||
                   res.motion_class == MOTION_MOVING))
    else $error("invalid motion class");
`endif

endmodule

`default_nettype wire
